/* design/gpm_pkg.sv */
// gpm_pkg: shared types and constants for the gpio port mode register block
// holds the request/response payload structs, operation codes and mode word layout
// no dependencies
package gpm_pkg;

    localparam int PIN_COUNT = 16;
    localparam int PIN_IDX_W = 4;
    localparam int MODE_W    = 12;
    localparam int FUNC_W    = 4;

    typedef enum logic [1:0] {
        OP_SET_MODE  = 2'd0,
        OP_GET_MODE  = 2'd1,
        OP_DRIVE     = 2'd2,
        OP_READ_OUT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_INPUT   = 2'd0,
        DIR_OUTPUT  = 2'd1,
        DIR_ALTFUNC = 2'd2,
        DIR_ANALOG  = 2'd3
    } dir_t;

    typedef struct packed {
        op_t                    op;
        logic [PIN_COUNT-1:0]   pin_mask;
        logic [MODE_W-1:0]      mode_word;
        logic [PIN_IDX_W-1:0]   pin_index;
        logic                   drive_value;
    } req_t;

    typedef struct packed {
        logic [MODE_W-1:0]      mode_out;
        logic                   output_bit;
    } rsp_t;

endpackage

/* design/gpio_port_mode_register_block.sv */
// gpio_port_mode_register_block: configuration store and output latch of one 16-pin port
// depends on gpm_pkg for payload types and operation codes
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// every request gives exactly one response, registered in the cycle after its transfer
// one request per cycle while req_stall is low: state update and response mux sit in front of the response register
// reset clears all mode fields, function numbers, the output latch and the response valid
// req_stall is high only while a response waits under rsp_stall
module gpio_port_mode_register_block
    import gpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic [PIN_COUNT-1:0][1:0]        dir_reg,   dir_next;
    logic [PIN_COUNT-1:0]             od_reg,    od_next;
    logic [PIN_COUNT-1:0][1:0]        pull_reg,  pull_next;
    logic [PIN_COUNT-1:0][1:0]        speed_reg, speed_next;
    logic [PIN_COUNT-1:0][FUNC_W-1:0] func_reg,  func_next;
    logic [PIN_COUNT-1:0]             latch_reg, latch_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    rsp_t                             rsp_reg,   rsp_next;

    logic       accept;
    logic [1:0] new_dir;
    logic [1:0] sel_dir;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign new_dir   = req.mode_word[6:5];
    assign sel_dir   = dir_reg[req.pin_index];
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        dir_next       = dir_reg;
        od_next        = od_reg;
        pull_next      = pull_reg;
        speed_next     = speed_reg;
        func_next      = func_reg;
        latch_next     = latch_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            case (req.op)
                OP_SET_MODE:
                begin
                    for (int p = 0; p < PIN_COUNT; p++)
                    begin
                        if (req.pin_mask[p])
                        begin
                            dir_next[p]   = new_dir;
                            od_next[p]    = req.mode_word[4];
                            pull_next[p]  = req.mode_word[3:2];
                            speed_next[p] = req.mode_word[1:0];
                            if (new_dir == DIR_ALTFUNC)
                            begin
                                func_next[p] = req.mode_word[11:8];
                            end
                        end
                    end
                end
                OP_GET_MODE:
                begin
                    // function number shows only for alternate function pins
                    rsp_next.mode_out = {
                        (sel_dir == DIR_ALTFUNC) ? func_reg[req.pin_index] : {FUNC_W{1'b0}},
                        1'b0,
                        sel_dir,
                        od_reg[req.pin_index],
                        pull_reg[req.pin_index],
                        speed_reg[req.pin_index]
                    };
                end
                OP_DRIVE:
                begin
                    if (req.drive_value)
                    begin
                        latch_next = latch_reg | req.pin_mask;
                    end
                    else
                    begin
                        latch_next = latch_reg & ~req.pin_mask;
                    end
                end
                OP_READ_OUT:
                begin
                    rsp_next.output_bit = latch_reg[req.pin_index];
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= '0;
            od_reg        <= '0;
            pull_reg      <= '0;
            speed_reg     <= '0;
            func_reg      <= '0;
            latch_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            dir_reg       <= dir_next;
            od_reg        <= od_next;
            pull_reg      <= pull_next;
            speed_reg     <= speed_next;
            func_reg      <= func_next;
            latch_reg     <= latch_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

/* design/gpm_checker.sv */
// gpm_checker: port-level assertions for gpio_port_mode_register_block
// depends on gpm_pkg; bound to gpio_port_mode_register_block at the end of this file
module gpm_checker
    import gpm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    logic req_xfer;
    assign req_xfer = req_valid && !req_stall;

    // a held response keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // a request transfer shows its response on the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> rsp_valid)
        else $error("missing response after request transfer");

    // only get mode returns a mode word
    a_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && req.op != OP_GET_MODE |=> rsp.mode_out == '0)
        else $error("mode word on a non get-mode response");

    // only read output returns a latch bit
    a_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && req.op != OP_READ_OUT |=> !rsp.output_bit)
        else $error("latch bit on a non read response");

    // the ignored bit of a returned mode word is always clear
    a_bit7_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && req.op == OP_GET_MODE |=> !rsp.mode_out[7])
        else $error("bit 7 set in returned mode word");

endmodule

bind gpio_port_mode_register_block gpm_checker u_gpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
